@@ sv/tks_pkg.sv @@
// Shared types, constants and key-ordering functions for the typed key sorter.
// No dependencies; every other file refers to this package by scoped names.
package tks_pkg;

  localparam int MAX_ENTRIES     = 64;
  localparam int SLOT_INDEX_BITS = 16;
  localparam int KEY_W           = 64;
  localparam int SLOT_PORT_W     = 16;
  localparam int IDX_W           = $clog2(MAX_ENTRIES);
  localparam int CNT_W           = $clog2(MAX_ENTRIES + 1);
  localparam int Q_DEPTH         = 2;

  // Key kind codes
  localparam logic [2:0] KIND_S64  = 3'd0;
  localparam logic [2:0] KIND_U64  = 3'd1;
  localparam logic [2:0] KIND_S32  = 3'd2;
  localparam logic [2:0] KIND_U32  = 3'd3;
  localparam logic [2:0] KIND_BOOL = 3'd4;

  typedef logic [SLOT_INDEX_BITS-1:0] slot_t;
  typedef logic [KEY_W-1:0]           key_t;
  typedef logic [CNT_W-1:0]           cnt_t;

  // One classified transaction handed from front to back
  typedef struct packed {
    logic       store_en;
    logic       last;
    logic       ovf;
    logic [2:0] kind;
    slot_t      slot;
    key_t       key;
  } tks_rec_t;

  typedef struct packed {
    logic full;
    logic valid;
  } tks_qstat_t;

  typedef enum logic [1:0] {
    BK_LOAD,
    BK_SCAN,
    BK_EMIT
  } tks_bstate_t;

  // Map a raw key onto an unsigned value whose plain order is the kind's order
  function automatic key_t order_key(input key_t raw, input logic [2:0] kind);
    key_t r;
    r = raw;
    case (kind)
      KIND_S64:  r = raw ^ {1'b1, {(KEY_W-1){1'b0}}};
      KIND_S32:  r = {32'd0, raw[31:0] ^ 32'h8000_0000};
      KIND_U32:  r = {32'd0, raw[31:0]};
      KIND_BOOL: r = {{(KEY_W-1){1'b0}}, raw[0]};
      default:   r = raw;
    endcase
    return r;
  endfunction

  function automatic slot_t slot_in(input logic [SLOT_PORT_W-1:0] s);
    return slot_t'({{SLOT_INDEX_BITS{1'b0}}, s});
  endfunction

  function automatic logic [SLOT_PORT_W-1:0] slot_out(input slot_t s);
    return SLOT_PORT_W'({{SLOT_PORT_W{1'b0}}, s});
  endfunction

endpackage

@@ sv/typed_key_sorter_top.sv @@
// Top level of the typed key sorter: front end, record queue and back end.
// Depends on tks_pkg, tks_front, tks_queue and tks_back.
//
// Usage:
//   Input channel (in_*): one hash table slot per transaction, accepted at a
//   clock edge with in_valid high and in_stall low. Empty slots are dropped;
//   occupied ones are buffered, up to 64 per table, the rest are dropped and
//   flagged on out_overflow. The slot with in_last_slot set closes the table.
//   Output channel (out_*): after the closing slot the buffered entries come
//   out in ascending key order under key_kind, equal keys in load order, with
//   out_last_result on the final one. A table with no entries gives nothing.
//   Config: cfg_wr_en writes cfg_wr_data into key_kind (0 signed 64, 1 unsigned
//   64, 2 signed 32, 3 unsigned 32, 4 bit 0; others unsigned 64).
//   Timing: slots load at one per cycle through a two-entry queue while in_stall
//   is low. Each result costs one full scan of the entry memory, whose single
//   read port sets the sort time. in_stall rises once the queue holds two
//   records, as it does while the back end sorts.
//   Reset: rst_n low clears counts, the queue, the output valid and key_kind.
//   Receiver stall: out_stall holds the output register and the sort pauses
//   on the next result; nothing is lost.
module typed_key_sorter_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [15:0] in_slot_index,
  input  logic        in_occupied,
  input  logic [63:0] in_key_value,
  input  logic        in_last_slot,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [15:0] out_sorted_slot,
  output logic [63:0] out_sorted_key,
  output logic        out_overflow,
  output logic        out_last_result,
  input  logic        cfg_wr_en,
  input  logic [2:0]  cfg_wr_data
);

  // Classified records travel front -> queue -> back
  tks_pkg::tks_rec_t   push_rec, pop_rec;
  tks_pkg::tks_qstat_t q_stat;
  logic                q_push, q_pop;

  tks_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_slot_index (in_slot_index),
    .in_occupied   (in_occupied),
    .in_key_value  (in_key_value),
    .in_last_slot  (in_last_slot),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_wr_data   (cfg_wr_data),
    .q_stat        (q_stat),
    .q_push        (q_push),
    .q_rec         (push_rec)
  );

  // Hold up to two records so the front keeps loading while the back drains
  tks_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_rec (push_rec),
    .pop      (q_pop),
    .pop_rec  (pop_rec),
    .stat     (q_stat)
  );

  // Buffer entries, then scan for the next smallest unemitted key per result
  tks_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .q_stat          (q_stat),
    .q_rec           (pop_rec),
    .q_pop           (q_pop),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_sorted_slot (out_sorted_slot),
    .out_sorted_key  (out_sorted_key),
    .out_overflow    (out_overflow),
    .out_last_result (out_last_result)
  );

endmodule

@@ sv/tks_front.sv @@
// Front end of the typed key sorter: accepts slots, drops empties, counts
// capacity, flags overflow and pushes classified records. Uses tks_pkg.
module tks_front (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [tks_pkg::SLOT_PORT_W-1:0]     in_slot_index,
  input  logic                                in_occupied,
  input  logic [tks_pkg::KEY_W-1:0]           in_key_value,
  input  logic                                in_last_slot,
  input  logic                                cfg_wr_en,
  input  logic [2:0]                          cfg_wr_data,
  input  tks_pkg::tks_qstat_t                 q_stat,
  output logic                                q_push,
  output tks_pkg::tks_rec_t                   q_rec
);

  tks_pkg::cnt_t count_r, count_nxt;
  logic          ovf_r, ovf_nxt;
  logic [2:0]    kind_r;
  logic          accept, full, store, drop;

  assign in_stall = q_stat.full;
  assign accept   = in_valid && !in_stall;
  assign full     = (count_r == tks_pkg::cnt_t'(tks_pkg::MAX_ENTRIES));
  assign store    = in_occupied && !full;
  assign drop     = in_occupied && full;

  always_comb begin
    q_rec.store_en = store;
    q_rec.last     = in_last_slot;
    q_rec.ovf      = ovf_r || drop;
    q_rec.kind     = kind_r;
    q_rec.slot     = tks_pkg::slot_in(in_slot_index);
    q_rec.key      = in_key_value;
    q_push         = accept && (store || in_last_slot);

    count_nxt = count_r;
    ovf_nxt   = ovf_r;
    if (accept) begin
      if (in_last_slot) begin
        count_nxt = '0;
        ovf_nxt   = 1'b0;
      end else begin
        count_nxt = count_r + {{(tks_pkg::CNT_W-1){1'b0}}, store};
        ovf_nxt   = ovf_r || drop;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      ovf_r   <= 1'b0;
      kind_r  <= tks_pkg::KIND_S64;
    end else begin
      count_r <= count_nxt;
      ovf_r   <= ovf_nxt;
      if (cfg_wr_en) begin
        kind_r <= cfg_wr_data;
      end
    end
  end

endmodule

@@ sv/tks_queue.sv @@
// Two-entry record queue between the sorter front and back ends.
// Uses tks_pkg for the record type and queue status struct.
module tks_queue (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  tks_pkg::tks_rec_t   push_rec,
  input  logic                pop,
  output tks_pkg::tks_rec_t   pop_rec,
  output tks_pkg::tks_qstat_t stat
);

  tks_pkg::tks_rec_t mem_r [tks_pkg::Q_DEPTH];
  logic       wr_ptr_r, rd_ptr_r;
  logic [1:0] cnt_r, cnt_nxt;
  logic       do_pop;

  assign stat.full  = (cnt_r == 2'd2);
  assign stat.valid = (cnt_r != 2'd0);
  assign pop_rec    = mem_r[rd_ptr_r];
  assign do_pop     = pop && stat.valid;

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !do_pop) begin
      cnt_nxt = cnt_r + 2'd1;
    end else if (do_pop && !push) begin
      cnt_nxt = cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push) begin
        wr_ptr_r <= !wr_ptr_r;
      end
      if (do_pop) begin
        rd_ptr_r <= !rd_ptr_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_rec;
    end
  end

endmodule

@@ sv/tks_back.sv @@
// Back end of the typed key sorter: buffers records in the entry memory and
// emits them by repeated stable minimum scans. Uses tks_pkg.
module tks_back (
  input  logic                            clk,
  input  logic                            rst_n,
  input  tks_pkg::tks_qstat_t             q_stat,
  input  tks_pkg::tks_rec_t               q_rec,
  output logic                            q_pop,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [tks_pkg::SLOT_PORT_W-1:0] out_sorted_slot,
  output logic [tks_pkg::KEY_W-1:0]       out_sorted_key,
  output logic                            out_overflow,
  output logic                            out_last_result
);

  tks_pkg::key_t  key_mem [tks_pkg::MAX_ENTRIES];
  tks_pkg::slot_t slot_mem[tks_pkg::MAX_ENTRIES];

  tks_pkg::tks_bstate_t state_r, state_nxt;

  tks_pkg::cnt_t ld_cnt_r, n_r, issue_r, rd_cnt_r, emit_cnt_r, cnt_after;
  logic [2:0]    kind_r;
  logic          ovf_r;
  logic [tks_pkg::MAX_ENTRIES-1:0] done_r;

  logic           rd_en, rd_v_r;
  tks_pkg::key_t  rd_key_r, cand_ok;
  tks_pkg::slot_t rd_slot_r;

  logic                       best_v_r;
  tks_pkg::key_t              best_ok_r, best_key_r;
  tks_pkg::slot_t             best_slot_r;
  logic [tks_pkg::IDX_W-1:0]  best_idx_r;

  logic take, start_sort, scan_done, out_free, emit, emit_last, better;

  assign q_pop     = (state_r == tks_pkg::BK_LOAD) && q_stat.valid;
  assign take      = q_pop;
  assign cnt_after = ld_cnt_r + {{(tks_pkg::CNT_W-1){1'b0}}, q_rec.store_en};
  assign rd_en     = (state_r == tks_pkg::BK_SCAN) && (issue_r < n_r);
  assign cand_ok   = tks_pkg::order_key(rd_key_r, kind_r);
  assign better    = rd_v_r && !done_r[rd_cnt_r[tks_pkg::IDX_W-1:0]] &&
                     (!best_v_r || (cand_ok < best_ok_r));
  assign scan_done = rd_v_r && ((rd_cnt_r + tks_pkg::cnt_t'(1)) == n_r);
  assign out_free  = !out_valid || !out_stall;
  assign emit_last = ((emit_cnt_r + tks_pkg::cnt_t'(1)) == n_r);

  always_comb begin
    state_nxt  = state_r;
    start_sort = 1'b0;
    emit       = 1'b0;
    case (state_r)
      tks_pkg::BK_LOAD: begin
        if (take && q_rec.last && (cnt_after != '0)) begin
          start_sort = 1'b1;
          state_nxt  = tks_pkg::BK_SCAN;
        end
      end
      tks_pkg::BK_SCAN: begin
        if (scan_done) begin
          state_nxt = tks_pkg::BK_EMIT;
        end
      end
      tks_pkg::BK_EMIT: begin
        if (out_free) begin
          emit      = 1'b1;
          state_nxt = emit_last ? tks_pkg::BK_LOAD : tks_pkg::BK_SCAN;
        end
      end
      default: state_nxt = tks_pkg::BK_LOAD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= tks_pkg::BK_LOAD;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Control counters and flags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ld_cnt_r   <= '0;
      n_r        <= '0;
      issue_r    <= '0;
      emit_cnt_r <= '0;
      rd_v_r     <= 1'b0;
      best_v_r   <= 1'b0;
      done_r     <= '0;
      out_valid  <= 1'b0;
    end else begin
      rd_v_r <= rd_en;
      if (rd_en) begin
        issue_r <= issue_r + tks_pkg::cnt_t'(1);
      end
      if (better) begin
        best_v_r <= 1'b1;
      end
      if (take) begin
        ld_cnt_r <= q_rec.last ? '0 : cnt_after;
      end
      if (start_sort) begin
        n_r        <= cnt_after;
        issue_r    <= '0;
        emit_cnt_r <= '0;
        best_v_r   <= 1'b0;
        done_r     <= '0;
      end
      if (emit) begin
        out_valid          <= 1'b1;
        done_r[best_idx_r] <= 1'b1;
        emit_cnt_r         <= emit_cnt_r + tks_pkg::cnt_t'(1);
        issue_r            <= '0;
        best_v_r           <= 1'b0;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_cnt_r <= issue_r;
    end
    if (take && q_rec.last) begin
      kind_r <= q_rec.kind;
      ovf_r  <= q_rec.ovf;
    end
    if (better) begin
      best_ok_r   <= cand_ok;
      best_key_r  <= rd_key_r;
      best_slot_r <= rd_slot_r;
      best_idx_r  <= rd_cnt_r[tks_pkg::IDX_W-1:0];
    end
    if (emit) begin
      out_sorted_slot <= tks_pkg::slot_out(best_slot_r);
      out_sorted_key  <= best_key_r;
      out_overflow    <= ovf_r;
      out_last_result <= emit_last;
    end
  end

  // Entry memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (take && q_rec.store_en) begin
      key_mem[ld_cnt_r[tks_pkg::IDX_W-1:0]]  <= q_rec.key;
      slot_mem[ld_cnt_r[tks_pkg::IDX_W-1:0]] <= q_rec.slot;
    end
    if (rd_en) begin
      rd_key_r  <= key_mem[issue_r[tks_pkg::IDX_W-1:0]];
      rd_slot_r <= slot_mem[issue_r[tks_pkg::IDX_W-1:0]];
    end
  end

  assert property (@(posedge clk) disable iff (!rst_n)
    ld_cnt_r <= tks_pkg::cnt_t'(tks_pkg::MAX_ENTRIES))
    else $error("entry count beyond capacity");

  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == tks_pkg::BK_EMIT) |-> best_v_r)
    else $error("scan ended without a candidate");

  assert property (@(posedge clk) disable iff (!rst_n)
    emit |-> !done_r[best_idx_r])
    else $error("entry emitted twice");

  assert property (@(posedge clk) disable iff (!rst_n)
    (emit && emit_last) |=> (ld_cnt_r == '0))
    else $error("load count not cleared after run");

endmodule

@@ tb/tks_sort_checker.sv @@
// Scoreboard for the typed key sorter: watches the slot, result and config ports.
// Predicts each sorted run and compares every result field. Depends on tks_pkg.
module tks_sort_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [15:0] in_slot_index,
  input  logic        in_occupied,
  input  logic [63:0] in_key_value,
  input  logic        in_last_slot,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [15:0] out_sorted_slot,
  input  logic [63:0] out_sorted_key,
  input  logic        out_overflow,
  input  logic        out_last_result,
  input  logic        cfg_wr_en,
  input  logic [2:0]  cfg_wr_data,
  output int          fail_count,
  output int          pending_results,
  output int          results_checked
);

  typedef struct packed {
    logic [15:0] slot;
    logic [63:0] key;
    logic        overflow;
    logic        last;
  } sorted_entry_t;

  sorted_entry_t   sorted_q[$];
  tks_pkg::key_t   held_key[tks_pkg::MAX_ENTRIES];
  logic [15:0]     held_slot[tks_pkg::MAX_ENTRIES];
  int              held_count = 0;
  logic            dropped = 1'b0;
  logic [2:0]      kind = tks_pkg::KIND_S64;
  int              errors = 0;
  int              checked = 0;

  // True when key a sorts strictly ahead of key b under kind k.
  function automatic bit ranks_below(input tks_pkg::key_t a, input tks_pkg::key_t b,
                                     input logic [2:0] k);
    case (k)
      tks_pkg::KIND_S64:  return $signed(a) < $signed(b);
      tks_pkg::KIND_S32:  return $signed(a[31:0]) < $signed(b[31:0]);
      tks_pkg::KIND_U32:  return a[31:0] < b[31:0];
      tks_pkg::KIND_BOOL: return a[0] < b[0];
      default:            return a < b;
    endcase
  endfunction

  // Stable insertion sort of the held entries; queue them and clear the table.
  task automatic emit_sorted();
    int order[tks_pkg::MAX_ENTRIES];
    int i;
    int j;
    sorted_entry_t e;
    for (i = 0; i < held_count; i++) begin
      j = i;
      while (j > 0 && ranks_below(held_key[i], held_key[order[j-1]], kind)) begin
        order[j] = order[j-1];
        j--;
      end
      order[j] = i;
    end
    for (i = 0; i < held_count; i++) begin
      e.slot     = held_slot[order[i]];
      e.key      = held_key[order[i]];
      e.overflow = dropped;
      e.last     = (i == held_count - 1);
      sorted_q.push_back(e);
    end
    held_count = 0;
    dropped    = 1'b0;
  endtask

  always @(posedge clk) begin : track
    sorted_entry_t want;
    if (!rst_n) begin
      sorted_q.delete();
      held_count = 0;
      dropped    = 1'b0;
      kind       = tks_pkg::KIND_S64;
    end else begin
      if (cfg_wr_en)
        kind = cfg_wr_data;
      if (in_valid && !in_stall) begin
        if (in_occupied) begin
          if (held_count < tks_pkg::MAX_ENTRIES) begin
            held_key[held_count]  = in_key_value;
            held_slot[held_count] = in_slot_index;
            held_count++;
          end else begin
            dropped = 1'b1;
          end
        end
        if (in_last_slot)
          emit_sorted();
      end
      if (out_valid && !out_stall) begin
        if (sorted_q.size() == 0) begin
          $display("%0t: unexpected result, slot %h key %h", $time, out_sorted_slot,
                   out_sorted_key);
          errors++;
        end else begin
          want = sorted_q.pop_front();
          checked++;
          if (out_sorted_slot !== want.slot) begin
            $display("%0t: sorted_slot expected %h, got %h", $time, want.slot,
                     out_sorted_slot);
            errors++;
          end
          if (out_sorted_key !== want.key) begin
            $display("%0t: sorted_key expected %h, got %h", $time, want.key, out_sorted_key);
            errors++;
          end
          if (out_overflow !== want.overflow) begin
            $display("%0t: overflow expected %b, got %b", $time, want.overflow, out_overflow);
            errors++;
          end
          if (out_last_result !== want.last) begin
            $display("%0t: last_result expected %b, got %b", $time, want.last,
                     out_last_result);
            errors++;
          end
        end
      end
    end
    fail_count      <= errors;
    pending_results <= sorted_q.size();
    results_checked <= checked;
  end

endmodule

@@ tb/tb_top.sv @@
// Testbench top for typed_key_sorter_top: clock, reset, slot stimulus and verdict.
// Depends on tks_pkg, the sorter RTL and tks_sort_checker.
module tb_top;

  // Longest quiet stretch: a 64-entry scan per result plus a receiver stall,
  // a sender gap and the settle time, taken many times over.
  localparam int WATCHDOG_LIMIT = 2500;
  // Cycles to let the slot queue and back end settle before a config write.
  localparam int SETTLE_CYCLES  = 12;
  localparam int RANDOM_SLOTS   = 185;
  localparam int CALM_TAIL      = 30;
  localparam logic [2:0] KIND_UNUSED_HI = 3'd7;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [15:0] in_slot_index = '0;
  logic        in_occupied = 1'b0;
  logic [63:0] in_key_value = '0;
  logic        in_last_slot = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [15:0] out_sorted_slot;
  logic [63:0] out_sorted_key;
  logic        out_overflow;
  logic        out_last_result;
  logic        cfg_wr_en = 1'b0;
  logic [2:0]  cfg_wr_data = '0;

  logic        quiet = 1'b0;     // set for the tail: no idling on either side
  int          fail_count;
  int          pending_results;
  int          results_checked;
  int          slots_sent = 0;
  int          tables_sent = 0;
  int          kind_writes = 0;
  int          stall_left = 0;
  int          idle_cycles = 0;
  logic [63:0] prev_key = '0;

  always #5 clk = ~clk;

  typed_key_sorter_top i_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_slot_index   (in_slot_index),
    .in_occupied     (in_occupied),
    .in_key_value    (in_key_value),
    .in_last_slot    (in_last_slot),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_sorted_slot (out_sorted_slot),
    .out_sorted_key  (out_sorted_key),
    .out_overflow    (out_overflow),
    .out_last_result (out_last_result),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_wr_data     (cfg_wr_data)
  );

  tks_sort_checker i_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_slot_index   (in_slot_index),
    .in_occupied     (in_occupied),
    .in_key_value    (in_key_value),
    .in_last_slot    (in_last_slot),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_sorted_slot (out_sorted_slot),
    .out_sorted_key  (out_sorted_key),
    .out_overflow    (out_overflow),
    .out_last_result (out_last_result),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_wr_data     (cfg_wr_data),
    .fail_count      (fail_count),
    .pending_results (pending_results),
    .results_checked (results_checked)
  );

  // Receiver side: stall in random bursts, none during the calm tail.
  always @(posedge clk) begin
    if (!rst_n || quiet) begin
      out_stall  <= 1'b0;
      stall_left <= 0;
    end else if (stall_left != 0) begin
      out_stall  <= 1'b1;
      stall_left <= stall_left - 1;
    end else if ($urandom_range(0, 5) == 0) begin
      out_stall  <= 1'b1;
      stall_left <= $urandom_range(0, 12);
    end else begin
      out_stall  <= 1'b0;
    end
  end

  // Watchdog: count cycles in which neither channel moves a transaction.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Watchdog expired with %0d results still due", pending_results);
      $display("typed_key_sorter_top: mismatch");
      $finish;
    end
  end

  // Drive one slot transaction, with an optional idle burst ahead of it, and
  // hold the payload until the sorter takes it.
  task automatic send_slot(input logic [15:0] s, input logic occ, input logic [63:0] k,
                           input logic lst);
    if (!quiet && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_slot_index <= s;
    in_occupied   <= occ;
    in_key_value  <= k;
    in_last_slot  <= lst;
    do @(posedge clk); while (in_stall);
    slots_sent++;
    if (lst)
      tables_sent++;
  endtask

  // Drop valid and hold off until every predicted result has come back,
  // then give the sorter time to go idle.
  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_results != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_kind(input logic [2:0] k);
    wait_drained();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= k;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    kind_writes++;
  endtask

  // Keys lean toward repeats, tiny values and sign boundaries so that stable
  // ordering and the narrow kinds get exercised; the rest are fully random.
  function automatic logic [63:0] pick_key(input logic [63:0] prev);
    logic [63:0] k;
    k = {$urandom, $urandom};
    case ($urandom_range(0, 7))
      0: k = prev;
      1: k = 64'($urandom_range(0, 3));
      2: k = {$urandom, 28'h0, 4'($urandom)};
      3: begin
        case ($urandom_range(0, 5))
          0:       k = 64'h0;
          1:       k = '1;
          2:       k = 64'h8000_0000_0000_0000;
          3:       k = 64'h7FFF_FFFF_FFFF_FFFF;
          4:       k = 64'h0000_0000_8000_0000;
          default: k = 64'h0000_0000_7FFF_FFFF;
        endcase
      end
      default: ;
    endcase
    return k;
  endfunction

  task automatic send_table(input int n, input logic all_occupied);
    logic [63:0] k;
    int i;
    for (i = 0; i < n; i++) begin
      k = pick_key(prev_key);
      prev_key = k;
      send_slot(16'($urandom), all_occupied || ($urandom_range(0, 4) != 0), k, i == n - 1);
    end
  endtask

  initial begin
    int  target;
    bit  overflow_done;
    overflow_done = 1'b0;

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Reset kind is signed 64: extremes, a skipped empty slot, an equal key
    // that must stay behind its twin, and an occupied closing slot.
    send_slot(16'h0000, 1'b1, 64'h0, 1'b0);
    send_slot(16'hFFFF, 1'b1, '1, 1'b0);
    send_slot(16'h0005, 1'b1, 64'h8000_0000_0000_0000, 1'b0);
    send_slot(16'h0006, 1'b1, 64'h7FFF_FFFF_FFFF_FFFF, 1'b0);
    send_slot(16'h0009, 1'b0, 64'h1234_5678_9ABC_DEF0, 1'b0);
    send_slot(16'h0007, 1'b1, '1, 1'b0);
    send_slot(16'h0008, 1'b1, 64'h1, 1'b1);
    // Empty table: nothing comes back.
    send_slot(16'h0003, 1'b0, '1, 1'b1);

    // Signed 32 on the low half, upper bits must not matter; the closing
    // slot is empty.
    write_kind(tks_pkg::KIND_S32);
    send_slot(16'h0001, 1'b1, 64'h0000_0001_8000_0000, 1'b0);
    send_slot(16'h0002, 1'b1, 64'hFFFF_FFFF_7FFF_FFFF, 1'b0);
    send_slot(16'h0004, 1'b1, 64'h8000_0000_0000_0005, 1'b0);
    send_slot(16'h0003, 1'b0, 64'h0, 1'b1);

    write_kind(tks_pkg::KIND_U32);
    send_slot(16'h0001, 1'b1, 64'h0000_0001_8000_0000, 1'b0);
    send_slot(16'h0002, 1'b1, 64'hFFFF_FFFF_0000_0001, 1'b1);

    // Boolean: only bit 0 counts, so the two odd keys tie in load order.
    write_kind(tks_pkg::KIND_BOOL);
    send_slot(16'h000A, 1'b1, '1, 1'b0);
    send_slot(16'h000B, 1'b1, 64'h2, 1'b0);
    send_slot(16'h000C, 1'b1, 64'h1, 1'b1);

    write_kind(tks_pkg::KIND_U64);
    send_slot(16'h0014, 1'b1, 64'h8000_0000_0000_0000, 1'b0);
    send_slot(16'h0015, 1'b1, 64'h7FFF_FFFF_FFFF_FFFF, 1'b1);

    // Unused kind codes sort as unsigned 64.
    write_kind(KIND_UNUSED_HI);
    send_slot(16'h0016, 1'b1, '1, 1'b0);
    send_slot(16'h0017, 1'b1, 64'h0, 1'b1);

    // Change the kind mid-table: the kind at the closing slot rules the sort.
    write_kind(tks_pkg::KIND_S64);
    send_slot(16'h001E, 1'b1, '1, 1'b0);
    send_slot(16'h001F, 1'b1, 64'h1, 1'b0);
    write_kind(tks_pkg::KIND_U64);
    send_slot(16'h0020, 1'b1, 64'h8000_0000_0000_0000, 1'b1);

    // Random tables: mostly short, a few medium, one that runs past capacity.
    target = slots_sent + RANDOM_SLOTS;
    while (slots_sent < target) begin
      if (!quiet && slots_sent >= target - CALM_TAIL)
        quiet <= 1'b1;
      if (!quiet) begin
        if ($urandom_range(0, 3) == 0)
          write_kind(3'($urandom_range(0, 7)));
        else if ($urandom_range(0, 5) == 0)
          wait_drained();
      end
      if (!overflow_done && slots_sent >= target - 150) begin
        send_table(tks_pkg::MAX_ENTRIES + 3, 1'b1);
        overflow_done = 1'b1;
      end else if ($urandom_range(0, 9) == 0) begin
        send_table($urandom_range(16, 40), 1'b0);
      end else begin
        send_table($urandom_range(1, 10), 1'b0);
      end
    end

    // Drain, then leave room for any stray result before the verdict.
    wait_drained();
    repeat (80) @(posedge clk);

    $display("Ran %0d slots in %0d tables with %0d key kind writes;", slots_sent,
             tables_sent, kind_writes);
    $display("%0d sorted entries compared, overflow and stable ties included.",
             results_checked);
    if (fail_count == 0 && pending_results == 0)
      $display("typed_key_sorter_top: match");
    else
      $display("typed_key_sorter_top: mismatch");
    $finish;
  end

endmodule
